[hdl/rbo_pkg.sv]
package rbo_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int SMP_W      = 16;
    localparam int ARG_W      = 12;
    localparam int DATA_W     = 32;
    localparam int FILL_OUT_W = 11;
    localparam int TAP_W      = 3;
    localparam int NUM_COEF   = 6;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 17;   // sample*coef >>> 15
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 16;

    // register map
    localparam logic [CFG_AW-1:0] CFG_TAP_COUNT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_COEF_0    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_COEF_LAST = 3'd6;

    localparam logic [TAP_W-1:0] TAPS_MIN = 3'd1;
    localparam logic [TAP_W-1:0] TAPS_MAX = 3'd6;

    typedef enum logic [1:0] {
        CMD_APPEND     = 2'd0,
        CMD_FIR_APPEND = 2'd1,
        CMD_READ       = 2'd2,
        CMD_FORWARD    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIR,
        ST_WRAP,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                    command;
        logic signed [SMP_W-1:0] sample;
        logic signed [ARG_W-1:0] offset_or_count;
        logic                    burst_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [FILL_OUT_W-1:0]    fill_level;
        logic                     overrun;
        logic                     underrun;
    } t_out_beat;

endpackage

[hdl/rbo_ram.sv]
module rbo_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rbo_wrap.sv]
module rbo_wrap import rbo_pkg::*; #(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int PW    = $clog2(DEPTH),
    localparam int WW    = ((PW > ARG_W) ? PW : ARG_W) + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [WW-1:0] i_value,
    output logic                 o_done,
    output logic [PW-1:0]        o_index
);

    localparam logic signed [WW-1:0] DEPTH_S = WW'(DEPTH);

    logic signed [WW-1:0] r_v;
    logic signed [WW-1:0] n_v;
    logic                 r_busy;
    logic                 n_busy;
    logic                 in_range;

    // one add or subtract of DEPTH per cycle until the value lands in range
    always_comb begin
        in_range = (r_v >= 0) && (r_v < DEPTH_S);
        o_done   = r_busy && in_range;
        n_v      = r_v;
        n_busy   = r_busy;
        if (i_start) begin
            n_v    = i_value;
            n_busy = 1'b1;
        end else if (r_busy) begin
            priority if (r_v < 0) begin
                n_v = r_v + DEPTH_S;
            end else if (r_v >= DEPTH_S) begin
                n_v = r_v - DEPTH_S;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_index = r_v[PW-1:0];

endmodule

[hdl/ring_buffer_overlap_add_unit.sv]
// Sample ring buffer with overlap-add FIR append. One command beat in gives one result
// beat out. The store is a 32-bit wide memory of DEPTH slots with one write and one read
// port; after reset a clearing pass writes zero to every slot, one per cycle, so no
// command is taken until the pass is through (configuration writes are taken at once).
// Plain append writes the sample at head. Filtered append does one memory
// read-modify-write per tap, taps being tap_count held to 1..6, overlapped so the single
// read port sets the pace; the clear of the slot past the taps goes with the first tap
// read. Read and forward pass the pointer through the wrap unit, which needs at most one
// DEPTH correction for DEPTH >= 2048 and about 2048/DEPTH otherwise; read then fetches
// the slot from memory.
// Overrun and underrun saturate the fill count; the fill_level field shows its low
// 11 bits.
module ring_buffer_overlap_add_unit import rbo_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command beats
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    // result beats
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    // register writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int WW = ((PW > ARG_W) ? PW : ARG_W) + 2;
    localparam int SW = ((FW > ARG_W) ? FW : ARG_W) + 2;

    localparam logic [PW:0]          DEPTH_A = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0]        LAST_A  = PW'(DEPTH - 1);
    localparam logic [FW-1:0]        DEPTH_F = FW'(DEPTH);
    localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);

    t_state r_state, n_state;

    // pointers and fill
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_clr;

    // registers
    logic [TAP_W-1:0]         r_tap_count;
    logic signed [COEF_W-1:0] r_coef [NUM_COEF];

    // command in flight
    t_cmd                     r_cmd, n_cmd;
    logic signed [SMP_W-1:0]  r_sample, n_sample;
    logic [TAP_W-1:0]         r_taps, n_taps;
    logic [TAP_W-1:0]         r_idx, n_idx;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [PW-1:0]            r_wr_addr, n_wr_addr;
    logic                     r_wr_pend, n_wr_pend;
    t_out_beat                r_res, n_res;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    // memory port
    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // wrap unit
    logic                 wrap_start;
    logic signed [WW-1:0] wrap_value;
    logic                 wrap_done;
    logic [PW-1:0]        wrap_index;

    // datapath helpers
    logic                     in_accept;
    logic [PW:0]              tap_sum, clr_sum;
    logic [PW-1:0]            tap_addr, clr_addr, head_inc;
    logic                     fill_full;
    logic [FW-1:0]            fill_bump;
    logic signed [SW-1:0]     fwd_fill;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [31:0]       prod_full;
    logic signed [DATA_W:0]   acc;
    logic [DATA_W-1:0]        acc_sat;
    logic [TAP_W-1:0]         taps_clamped;

    rbo_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rbo_wrap #(
        .DEPTH (DEPTH)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wrap_start),
        .i_value (wrap_value),
        .o_done  (wrap_done),
        .o_index (wrap_index)
    );

    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot addresses near head: offsets stay below DEPTH, one compare wraps them
    always_comb begin
        tap_sum  = {1'b0, r_head} + (PW + 1)'(r_idx);
        clr_sum  = {1'b0, r_head} + (PW + 1)'(r_taps);
        tap_addr = (tap_sum >= DEPTH_A) ? PW'(tap_sum - DEPTH_A) : tap_sum[PW-1:0];
        clr_addr = (clr_sum >= DEPTH_A) ? PW'(clr_sum - DEPTH_A) : clr_sum[PW-1:0];
        head_inc = (r_head == LAST_A) ? '0 : r_head + 1'b1;
        fill_full = (r_fill >= DEPTH_F);
        fill_bump = fill_full ? DEPTH_F : r_fill + 1'b1;
        fwd_fill  = $signed(SW'(r_fill)) - SW'(i_in_data.offset_or_count);
        taps_clamped = (r_tap_count < TAPS_MIN) ? TAPS_MIN :
                       (r_tap_count > TAPS_MAX) ? TAPS_MAX : r_tap_count;
    end

    // tap product, floor of the Q30 product to Q15
    always_comb begin
        coef_sel  = (r_idx < TAPS_MAX) ? r_coef[r_idx] : '0;
        prod_full = r_sample * coef_sel;
    end

    // accumulate into the slot read the cycle before, saturating to 32 bits
    always_comb begin
        acc = $signed({mem_rdata[DATA_W-1], mem_rdata}) + (DATA_W + 1)'(r_prod);
        if (acc[DATA_W] != acc[DATA_W-1]) begin
            acc_sat = acc[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                  : {1'b0, {(DATA_W - 1){1'b1}}};
        end else begin
            acc_sat = acc[DATA_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_cmd       = r_cmd;
        n_sample    = r_sample;
        n_taps      = r_taps;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_addr;
        mem_wdata   = acc_sat;
        mem_re      = 1'b0;
        mem_raddr   = tap_addr;
        wrap_start  = 1'b0;
        wrap_value  = $signed(WW'(r_tail)) + WW'(i_in_data.offset_or_count);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == LAST_A) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_cmd              = i_in_data.command;
                    n_sample           = i_in_data.sample;
                    n_res.read_data    = '0;
                    n_res.overrun      = 1'b0;
                    n_res.underrun     = 1'b0;
                    n_res.fill_level   = FILL_OUT_W'(r_fill);
                    unique case (i_in_data.command)
                        CMD_APPEND: begin
                            mem_we           = 1'b1;
                            mem_waddr        = r_head;
                            mem_wdata        = DATA_W'(i_in_data.sample);
                            n_head           = head_inc;
                            n_fill           = fill_bump;
                            n_res.fill_level = FILL_OUT_W'(fill_bump);
                            n_res.overrun    = fill_full;
                            n_state          = ST_DONE;
                        end
                        CMD_FIR_APPEND: begin
                            n_taps    = taps_clamped;
                            n_idx     = '0;
                            n_wr_pend = 1'b0;
                            n_state   = ST_FIR;
                        end
                        CMD_READ: begin
                            wrap_start = 1'b1;
                            n_state    = ST_WRAP;
                        end
                        CMD_FORWARD: begin
                            priority if (fwd_fill < 0) begin
                                n_fill         = '0;
                                n_res.underrun = 1'b1;
                            end else if (fwd_fill > DEPTH_S) begin
                                n_fill = DEPTH_F;
                            end else begin
                                n_fill = fwd_fill[FW-1:0];
                            end
                            n_res.fill_level = FILL_OUT_W'(n_fill);
                            wrap_start       = 1'b1;
                            n_state          = ST_WRAP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIR: begin
                // write of tap i-1 overlaps read of tap i; their slots differ, and the
                // cleared slot lies past all taps, so no forwarding is needed
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                end else if (r_idx == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = clr_addr;
                    mem_wdata = '0;
                end
                if (r_idx < r_taps) begin
                    mem_re    = 1'b1;
                    n_prod    = prod_full[31:15];
                    n_wr_addr = tap_addr;
                    n_wr_pend = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_wr_pend        = 1'b0;
                    n_head           = head_inc;
                    n_fill           = fill_bump;
                    n_res.fill_level = FILL_OUT_W'(fill_bump);
                    n_res.overrun    = fill_full;
                    n_state          = ST_DONE;
                end
            end
            ST_WRAP: begin
                if (wrap_done) begin
                    if (r_cmd == CMD_READ) begin
                        mem_re    = 1'b1;
                        mem_raddr = wrap_index;
                        n_state   = ST_RDWAIT;
                    end else begin
                        n_tail  = wrap_index;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RDWAIT: begin
                n_res.read_data = mem_rdata;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_tap_count <= TAPS_MIN;
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TAP_COUNT) begin
                    r_tap_count <= i_cfg_data[TAP_W-1:0];
                end else if (i_cfg_addr <= CFG_COEF_LAST) begin
                    r_coef[i_cfg_addr - CFG_COEF_0] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_sample  <= n_sample;
        r_taps    <= n_taps;
        r_idx     <= n_idx;
        r_prod    <= n_prod;
        r_wr_addr <= n_wr_addr;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

[hdl/rbo_checker.sv]
module rbo_checker import rbo_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    localparam logic [FILL_OUT_W-1:0] DEPTH_O = FILL_OUT_W'(DEPTH);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("command taken while previous one in flight");

    a_underrun_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.underrun |-> o_out_data.fill_level == '0)
        else $error("underrun with nonzero fill");

    a_overrun_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overrun
            |-> o_out_data.fill_level == DEPTH_O && !o_out_data.underrun)
        else $error("overrun without full fill");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open after reset");

endmodule

bind ring_buffer_overlap_add_unit rbo_checker #(.DEPTH(DEPTH)) u_rbo_checker (.*);

[bench/ring_buffer_overlap_add_unit_tb.sv]
module ring_buffer_overlap_add_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbo_pkg::*;

    localparam int     RING_DEPTH = DEPTH_DEF;
    // worst command is a read with two wrap corrections, plus output register slack
    localparam int     SETTLE_CYCLES = 24;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_beat         o_out_data;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    // shadow copy of the ring and its registers
    logic signed [DATA_W-1:0] ring_mem [RING_DEPTH];
    int                       head_ptr;
    int                       tail_ptr;
    int                       fill_cnt;
    logic [TAP_W-1:0]         tap_reg;
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

    t_out_beat pending_results [$];   // predicted result beats, oldest first
    int        mismatch_cnt = 0;
    bit        idle_on      = 1'b1;   // random gaps on both sides
    int        rx_hold_len  = 0;      // request for one long receiver hold-off

    ring_buffer_overlap_add_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side stall: random bursts, or one long hold-off on request so the
    // block backs up and stalls its command input.
    initial begin : out_stall_gen
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 13);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%t: result beat with nothing pending:", $realtime);
                    $display("  data %0d fill %0d ovr %b und %b", o_out_data.read_data,
                             o_out_data.fill_level, o_out_data.overrun,
                             o_out_data.underrun);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.read_data  !== want.read_data  ||
                    o_out_data.fill_level !== want.fill_level ||
                    o_out_data.overrun    !== want.overrun    ||
                    o_out_data.underrun   !== want.underrun) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%t: result mismatch:", $realtime);
                        $display("  exp data %0d fill %0d ovr %b und %b", want.read_data,
                                 want.fill_level, want.overrun, want.underrun);
                        $display("  got data %0d fill %0d ovr %b und %b",
                                 o_out_data.read_data, o_out_data.fill_level,
                                 o_out_data.overrun, o_out_data.underrun);
                    end
                end
            end
        end
    end

    // Any signed value down to a slot index, wrapping both ways.
    function automatic int ring_index(input int v);
        int r;
        r = v % RING_DEPTH;
        if (r < 0)
            r += RING_DEPTH;
        return r;
    endfunction

    // Head moves on for every append; fill sticks at the top with a flag.
    function automatic logic bump_fill_level();
        head_ptr = ring_index(head_ptr + 1);
        if (fill_cnt >= RING_DEPTH) begin
            fill_cnt = RING_DEPTH;
            return 1'b1;
        end
        fill_cnt++;
        return 1'b0;
    endfunction

    // Applies one command to the shadow ring and returns the result beat it gives.
    function automatic t_out_beat ring_apply_cmd(input t_in_beat b);
        t_out_beat res;
        int        arg;
        int        nf;
        int        taps;
        int        at;
        longint    smp;
        longint    acc;
        res = '0;
        arg = b.offset_or_count;
        smp = b.sample;
        case (b.command)
            CMD_APPEND: begin
                ring_mem[head_ptr] = DATA_W'(smp);
                res.overrun = bump_fill_level();
            end
            CMD_FIR_APPEND: begin
                // tap count 0 behaves as 1, 7 as 6
                taps = tap_reg;
                if (taps < 1)
                    taps = 1;
                if (taps > NUM_COEF)
                    taps = NUM_COEF;
                ring_mem[ring_index(head_ptr + taps)] = '0;
                for (int k = 0; k < taps; k++) begin
                    at  = ring_index(head_ptr + k);
                    // Q15 x Q1.15, floor back to Q15, then saturating accumulate
                    acc = longint'(ring_mem[at]) + ((smp * longint'(coef_reg[k])) >>> 15);
                    if (acc > SAT_HI)
                        acc = SAT_HI;
                    else if (acc < SAT_LO)
                        acc = SAT_LO;
                    ring_mem[at] = DATA_W'(acc);
                end
                res.overrun = bump_fill_level();
            end
            CMD_READ: begin
                res.read_data = ring_mem[ring_index(tail_ptr + arg)];
            end
            default: begin
                // negative count walks tail back and raises fill, no flag
                nf       = fill_cnt - arg;
                tail_ptr = ring_index(tail_ptr + arg);
                if (nf < 0) begin
                    nf           = 0;
                    res.underrun = 1'b1;
                end else if (nf > RING_DEPTH) begin
                    nf = RING_DEPTH;
                end
                fill_cnt = nf;
            end
        endcase
        res.fill_level = FILL_OUT_W'(fill_cnt);
        return res;
    endfunction

    function automatic t_in_beat cmd_beat(input t_cmd c, input int smp, input int arg,
                                          input bit last);
        t_in_beat b;
        b.command         = c;
        b.sample          = SMP_W'(smp);
        b.offset_or_count = ARG_W'(arg);
        b.burst_last      = last;
        return b;
    endfunction

    // Mostly appends and short reads/forwards around tail; a few wide offsets and
    // big or negative forward counts to push fill against both limits.
    function automatic t_in_beat rand_cmd_beat();
        t_in_beat b;
        int       pick;
        b.sample          = SMP_W'($urandom);
        b.burst_last      = 1'($urandom);
        b.offset_or_count = ARG_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            b.command = CMD_APPEND;
        end else if (pick < 55) begin
            b.command = CMD_FIR_APPEND;
        end else if (pick < 80) begin
            b.command = CMD_READ;
            if ($urandom_range(0, 4) != 0)
                b.offset_or_count = ARG_W'(int'($urandom_range(0, 64)) - 32);
        end else begin
            b.command = CMD_FORWARD;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                b.offset_or_count = ARG_W'($urandom_range(0, 6));
            else if (pick == 8)
                b.offset_or_count = ARG_W'(-int'($urandom_range(1, 300)));
        end
        return b;
    endfunction

    // Offers one command beat and holds it until taken. Valid stays high on
    // return so back-to-back beats need no extra edge.
    task automatic push_cmd(input t_in_beat b);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(ring_apply_cmd(b));
    endtask

    // Sender goes quiet until every predicted beat is back, then lets the
    // block settle so a register write lands on an idle unit.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes tap count then coef 0..5 on consecutive edges.
    task automatic load_filter(input logic [CFG_DW-1:0] taps_word,
                               input logic [NUM_COEF*COEF_W-1:0] coef_vec);
        tap_reg = taps_word[TAP_W-1:0];
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_TAP_COUNT;
        i_cfg_data <= taps_word;
        @(posedge i_clk);
        for (int k = 0; k < NUM_COEF; k++) begin
            coef_reg[k] = coef_vec[k*COEF_W +: COEF_W];
            i_cfg_addr <= CFG_COEF_0 + CFG_AW'(k);
            i_cfg_data <= coef_vec[k*COEF_W +: COEF_W];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
            push_cmd(rand_cmd_beat());
    endtask

    // Extremes of every field, each command, wrap of offsets both ways,
    // underrun, fill pushed to the top by a negative forward, then overrun.
    task automatic test_directed();
        // coef 5..0 = 0, 1 LSB, -1 LSB, 0.5, -1.0, ~1.0
        load_filter({13'($urandom), 3'd3},
                    {16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'h8000, 16'h7FFF});
        push_cmd(cmd_beat(CMD_APPEND,      32767,     0, 1'b0));
        push_cmd(cmd_beat(CMD_APPEND,     -32768,     0, 1'b0));
        push_cmd(cmd_beat(CMD_APPEND,          0,     0, 1'b1));
        push_cmd(cmd_beat(CMD_FIR_APPEND,  32767,     0, 1'b0));
        push_cmd(cmd_beat(CMD_FIR_APPEND, -32768,     0, 1'b0));
        push_cmd(cmd_beat(CMD_FIR_APPEND,     -1,     0, 1'b0));
        push_cmd(cmd_beat(CMD_FIR_APPEND,      1,     0, 1'b1));
        push_cmd(cmd_beat(CMD_READ,            0,     0, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0,    -1, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0,  2047, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0, -2048, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0,  1024, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0,     0, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0,     3, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0,  2047, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0, -2048, 1'b0));
        push_cmd(cmd_beat(CMD_APPEND,          5,     0, 1'b0));
        push_cmd(cmd_beat(CMD_FIR_APPEND,    100,     0, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0, -1024, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0,    -1, 1'b0));
        push_cmd(cmd_beat(CMD_FORWARD,         0,     1, 1'b0));
        push_cmd(cmd_beat(CMD_READ,            0,     5, 1'b0));
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        load_filter({13'($urandom), 3'd4}, {$urandom(), $urandom(), $urandom()});
        rx_hold_len = 400;
        run_random(40);
        wait_drain();
    endtask

    // Several filter settings, tap count clamped at both ends among them.
    task automatic test_filter_settings();
        load_filter({13'($urandom), 3'd0}, {NUM_COEF{16'h7FFF}});
        run_random(300);
        wait_drain();
        load_filter({13'($urandom), 3'd7}, {NUM_COEF{16'h8000}});
        run_random(300);
        wait_drain();
        load_filter({13'($urandom), 3'd6}, {$urandom(), $urandom(), $urandom()});
        run_random(300);
        wait_drain();
        for (int k = 0; k < 2; k++) begin
            load_filter({13'($urandom), 3'($urandom_range(1, 5))},
                        {$urandom(), $urandom(), $urandom()});
            run_random(300);
            wait_drain();
        end
    endtask

    // Closing stretch at full rate, no gaps on either side.
    task automatic test_full_rate();
        idle_on = 1'b0;
        load_filter({13'($urandom), 3'd2}, {$urandom(), $urandom(), $urandom()});
        run_random(250);
        wait_drain();
    endtask

    initial begin
        for (int k = 0; k < RING_DEPTH; k++)
            ring_mem[k] = '0;
        head_ptr = 0;
        tail_ptr = 0;
        fill_cnt = 0;
        tap_reg  = TAPS_MIN;
        for (int k = 0; k < NUM_COEF; k++)
            coef_reg[k] = '0;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the clearing pass after reset shows up as input stall
        test_directed();
        test_backpressure();
        test_filter_settings();
        test_full_rate();

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
